>>> rtl/core/cesu8dv_pkg.sv
//------------------------------------------------------------------------------
// cesu8dv_pkg
// shared types, constants and the byte classifier of the cesu-8 stream decoder
//------------------------------------------------------------------------------
`default_nettype none

package cesu8dv_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int CP_W       = 21;
	localparam int CNT_OUT_W  = 16;
	localparam int OUT_DATA_W = 40;
	localparam int PART_W     = 14;
	localparam int SEEN_W     = 3;
	localparam int QUEUE_W    = 2;

	localparam logic [CP_W-1:0] PAIR_BASE = 21'h10000;
	localparam logic [5:0]      ED_LOW    = 6'h0d;

	typedef enum logic [3:0] {
		CLS_ASCII,
		CLS_LEAD2,
		CLS_E0,
		CLS_LEAD3,
		CLS_ED,
		CLS_CONT_LO,
		CLS_CONT_MID,
		CLS_CONT_HI,
		CLS_BAD
	} byte_class_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_TWO,
		KIND_E0,
		KIND_THREE,
		KIND_ED,
		KIND_PAIR
	} seq_kind_t;

	typedef struct packed {
		logic [IN_DATA_W-1:0] data;
		logic                 last;
		byte_class_t          cls;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	function automatic byte_class_t classify(input logic [IN_DATA_W-1:0] b);
		byte_class_t c;
		if (b <= 8'h7f) begin
			c = CLS_ASCII;
		end else if (b <= 8'h9f) begin
			c = CLS_CONT_LO;
		end else if (b <= 8'haf) begin
			c = CLS_CONT_MID;
		end else if (b <= 8'hbf) begin
			c = CLS_CONT_HI;
		end else if (b >= 8'hc2 && b <= 8'hdf) begin
			c = CLS_LEAD2;
		end else if (b == 8'he0) begin
			c = CLS_E0;
		end else if (b == 8'hed) begin
			c = CLS_ED;
		end else if ((b >= 8'he1 && b <= 8'hec) || b == 8'hee || b == 8'hef) begin
			c = CLS_LEAD3;
		end else begin
			c = CLS_BAD;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/cesu8dv_front.sv
//------------------------------------------------------------------------------
// cesu8dv_front
// accepts input bytes, classifies them and holds them in a two-entry queue
//------------------------------------------------------------------------------
`default_nettype none

module cesu8dv_front import cesu8dv_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,  // data_byte
	input  wire logic                 s_tlast,  // last_byte
	input  wire logic                 pop,
	output q_head_t                   head
);

	q_entry_t           fifo_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [QUEUE_W-1:0] count_q;
	logic               push;
	logic               do_pop;

	assign s_tready = (count_q != QUEUE_W'(2));
	assign push     = s_tvalid & s_tready;
	assign do_pop   = pop & head.valid;

	assign head.valid = (count_q != '0);
	assign head.entry = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{data: s_tdata, last: s_tlast, cls: classify(s_tdata)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + QUEUE_W'(1);
				2'b01:   count_q <= count_q - QUEUE_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/cesu8dv_back.sv
//------------------------------------------------------------------------------
// cesu8dv_back
// runs the cesu-8 sequence state per byte and registers one result per byte
//------------------------------------------------------------------------------
`default_nettype none

module cesu8dv_back import cesu8dv_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  q_head_t                    head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // code_point, string_ok, char_count, zero pad
	output logic                       m_tlast,  // string_done
	output logic                       m_tuser   // point_valid
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	seq_kind_t             kind_q, kind_d;
	logic [SEEN_W-1:0]     seen_q, seen_d;
	logic [PART_W-1:0]     part_q, part_d;
	logic                  err_q, err_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;

	logic                  out_valid_q;
	logic [CP_W-1:0]       cp_q;
	logic                  ok_q;
	logic [CNT_OUT_W-1:0]  cnt_out_q;
	logic                  last_q;
	logic                  pv_q;

	logic                  emit;
	logic                  bad;
	logic [CP_W-1:0]       cp;
	logic                  ok;
	logic                  is_cont;
	logic [5:0]            cbits;
	logic [IN_DATA_W-1:0]  b;
	byte_class_t           cls;
	logic [31:0]           cnt_wide;

	assign b       = head.entry.data;
	assign cls     = head.entry.cls;
	assign cbits   = b[5:0];
	assign is_cont = (cls == CLS_CONT_LO) || (cls == CLS_CONT_MID) || (cls == CLS_CONT_HI);
	assign pop     = head.valid & (~out_valid_q | m_tready);

	always_comb begin
		kind_d = kind_q;
		seen_d = seen_q;
		part_d = part_q;
		err_d  = err_q;
		emit   = 1'b0;
		bad    = 1'b0;
		cp     = '0;
		if (!err_q) begin
			unique case (kind_q)
				KIND_NONE: begin
					unique case (cls)
						CLS_ASCII: begin
							emit = 1'b1;
							cp   = CP_W'(b);
						end
						CLS_LEAD2: begin
							kind_d = KIND_TWO;
							part_d = PART_W'(b[4:0]);
							seen_d = SEEN_W'(1);
						end
						CLS_E0: begin
							kind_d = KIND_E0;
							part_d = '0;
							seen_d = SEEN_W'(1);
						end
						CLS_LEAD3: begin
							kind_d = KIND_THREE;
							part_d = PART_W'(b[3:0]);
							seen_d = SEEN_W'(1);
						end
						CLS_ED: begin
							kind_d = KIND_ED;
							part_d = PART_W'(ED_LOW);
							seen_d = SEEN_W'(1);
						end
						default: bad = 1'b1;
					endcase
				end
				KIND_TWO: begin
					if (seen_q == SEEN_W'(1) && is_cont) begin
						emit = 1'b1;
						cp   = CP_W'({part_q[4:0], cbits});
						kind_d = KIND_NONE;
						seen_d = '0;
						part_d = '0;
					end else begin
						bad = 1'b1;
					end
				end
				KIND_E0: begin
					if (seen_q == SEEN_W'(1) && (cls == CLS_CONT_MID || cls == CLS_CONT_HI)) begin
						kind_d = KIND_THREE;
						part_d = PART_W'(cbits);
						seen_d = SEEN_W'(2);
					end else begin
						bad = 1'b1;
					end
				end
				KIND_THREE: begin
					if (is_cont && seen_q == SEEN_W'(1)) begin
						part_d = PART_W'({part_q[3:0], cbits});
						seen_d = SEEN_W'(2);
					end else if (is_cont && seen_q == SEEN_W'(2)) begin
						emit   = 1'b1;
						cp     = CP_W'({part_q[9:0], cbits});
						kind_d = KIND_NONE;
						seen_d = '0;
						part_d = '0;
					end else begin
						bad = 1'b1;
					end
				end
				KIND_ED: begin
					if (seen_q == SEEN_W'(1) && cls == CLS_CONT_LO) begin
						kind_d = KIND_THREE;
						part_d = PART_W'({ED_LOW[3:0], cbits});
						seen_d = SEEN_W'(2);
					end else if (seen_q == SEEN_W'(1) && cls == CLS_CONT_MID) begin
						kind_d = KIND_PAIR;
						part_d = PART_W'(b[3:0]);
						seen_d = SEEN_W'(2);
					end else begin
						bad = 1'b1;
					end
				end
				KIND_PAIR: begin
					if (seen_q == SEEN_W'(2) && is_cont) begin
						part_d = PART_W'({part_q[3:0], cbits});
						seen_d = SEEN_W'(3);
					end else if (seen_q == SEEN_W'(3) && cls == CLS_ED) begin
						seen_d = SEEN_W'(4);
					end else if (seen_q == SEEN_W'(4) && cls == CLS_CONT_HI) begin
						part_d = PART_W'({part_q[9:0], b[3:0]});
						seen_d = SEEN_W'(5);
					end else if (seen_q == SEEN_W'(5) && is_cont) begin
						emit   = 1'b1;
						cp     = PAIR_BASE + CP_W'({part_q, cbits});
						kind_d = KIND_NONE;
						seen_d = '0;
						part_d = '0;
					end else begin
						bad = 1'b1;
					end
				end
				default: bad = 1'b1;
			endcase
		end
		if (bad) begin
			err_d  = 1'b1;
			kind_d = KIND_NONE;
			seen_d = '0;
			part_d = '0;
		end
		cnt_d = (emit && cnt_q != CNT_MAX) ? cnt_q + COUNT_BITS'(1) : cnt_q;
		ok    = head.entry.last & ~err_d & (kind_d == KIND_NONE);
	end

	assign cnt_wide = 32'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_NONE;
			seen_q      <= '0;
			part_q      <= '0;
			err_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.entry.last) begin
					kind_q <= KIND_NONE;
					seen_q <= '0;
					part_q <= '0;
					err_q  <= 1'b0;
					cnt_q  <= '0;
				end else begin
					kind_q <= kind_d;
					seen_q <= seen_d;
					part_q <= part_d;
					err_q  <= err_d;
					cnt_q  <= cnt_d;
				end
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pv_q      <= emit;
			cp_q      <= cp;
			ok_q      <= ok;
			cnt_out_q <= cnt_wide[CNT_OUT_W-1:0];
			last_q    <= head.entry.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, cnt_out_q, ok_q, cp_q};
	assign m_tlast  = last_q;
	assign m_tuser  = pv_q;

endmodule

`default_nettype wire

>>> rtl/core/cesu8_stream_decode_validate.sv
//------------------------------------------------------------------------------
// cesu8_stream_decode_validate
// cesu-8 byte stream decoder with per-string validity and character count
//------------------------------------------------------------------------------
// path: a byte taken is written into the two-entry queue, then registered into the
// output register when the back part pops it and updates the sequence state
// throughput: one byte per cycle while the receiver keeps m_tready high;
// a two-entry queue between front and back lets each side stall on its own
// reset: arst_n clears queue, sequence state, error flag, count and output valid
//------------------------------------------------------------------------------
`default_nettype none

module cesu8_stream_decode_validate import cesu8dv_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // data_byte
	input  wire logic                  s_tlast,  // last_byte
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // code_point, string_ok, char_count, zero pad
	output logic                       m_tlast,  // string_done
	output logic                       m_tuser   // point_valid
);

	q_head_t head;
	logic    pop;

	cesu8dv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.pop      (pop),
		.head     (head)
	);

	cesu8dv_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

>>> rtl/core/cesu8dv_checker.sv
//------------------------------------------------------------------------------
// cesu8dv_checker
// port-level checks of the cesu-8 stream decoder, bound to the top level
//------------------------------------------------------------------------------
`default_nettype none

module cesu8dv_checker import cesu8dv_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic [IN_DATA_W-1:0]  s_tdata,
	input wire logic                  s_tlast,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic                  m_tlast,
	input wire logic                  m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result changed while stalled");

	// string_ok only on the last result of a string
	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[CP_W] |-> m_tlast)
		else $error("string_ok without string_done");

	// no code point unless a character completed
	a_cp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[CP_W-1:0] == '0)
		else $error("code point without point_valid");

	// decoded values stay within the unicode range
	a_cp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[CP_W-1:0] <= 21'h10ffff)
		else $error("code point out of range");

	// an accepted byte taken while the output is empty is followed by a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
		else $error("result missing after transfer");

endmodule

bind cesu8_stream_decode_validate cesu8dv_checker u_cesu8dv_checker (.*);

`default_nettype wire

>>> verif/tb_cesu8_stream_decode_validate.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_cesu8_stream_decode_validate
// self-checking bench: strings of well-formed, corrupted and noise bytes are
// streamed in with random gaps on both sides; a behavioral decoder predicts
// code point, validity and count for every byte, and each output transfer is
// compared field by field against the oldest prediction
//------------------------------------------------------------------------------

module tb_cesu8_stream_decode_validate;
	import cesu8dv_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_xfer_t;

	typedef struct packed {
		logic        point_valid;
		logic [20:0] code_point;
		logic        string_done;
		logic        string_ok;
		logic [15:0] char_count;
	} dec_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	byte_xfer_t  bytes_to_send[$];
	dec_result_t results_due[$];
	logic [7:0]  str_bytes[$];

	// decoder state
	seq_kind_t   dec_kind = KIND_NONE;
	logic [2:0]  dec_seen = '0;
	logic [20:0] dec_part = '0;
	logic        dec_err = 1'b0;
	logic [15:0] dec_count = '0;

	int  mismatches = 0;
	int  tx_total = 0;
	int  tx_accepted = 0;
	int  tx_gap = 0;
	bit  tx_no_idle = 1'b0;
	bit  in_fired = 1'b0;
	bit  out_fired = 1'b0;
	int  rx_wait = 0;
	bit  rx_no_idle = 1'b0;
	int  rx_hold_left = 0;
	int  hold_ticket = 0;
	int  hold_seen = 0;

	cesu8_stream_decode_validate u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic is_cont(input logic [7:0] b);
		return b >= 8'h80 && b <= 8'hbf;
	endfunction

	function automatic dec_result_t decode_byte(input logic [7:0] b, input logic last);
		dec_result_t r;
		logic        hit;
		logic        bad;
		logic [20:0] cp;
		logic [5:0]  cont;
		r = '0;
		hit = 1'b0;
		bad = 1'b0;
		cp = '0;
		cont = b[5:0];
		if (!dec_err) begin
			case (dec_kind)
				KIND_NONE: begin
					dec_seen = 3'd1;
					if (b <= 8'h7f) begin
						cp = {13'd0, b};
						hit = 1'b1;
						dec_seen = 3'd0;
					end else if (b >= 8'hc2 && b <= 8'hdf) begin
						dec_kind = KIND_TWO;
						dec_part = {16'd0, b[4:0]};
					end else if (b == 8'he0) begin
						dec_kind = KIND_E0;
						dec_part = '0;
					end else if ((b >= 8'he1 && b <= 8'hec) || b == 8'hee || b == 8'hef) begin
						dec_kind = KIND_THREE;
						dec_part = {17'd0, b[3:0]};
					end else if (b == 8'hed) begin
						dec_kind = KIND_ED;
						dec_part = 21'h0d;
					end else begin
						bad = 1'b1;
					end
				end
				KIND_TWO: begin
					if (dec_seen == 3'd1 && is_cont(b)) begin
						cp = (dec_part << 6) | cont;
						hit = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
				KIND_E0: begin
					if (dec_seen == 3'd1 && b >= 8'ha0 && b <= 8'hbf) begin
						dec_kind = KIND_THREE;
						dec_part = {15'd0, cont};
						dec_seen = 3'd2;
					end else begin
						bad = 1'b1;
					end
				end
				KIND_THREE: begin
					if (!is_cont(b)) begin
						bad = 1'b1;
					end else if (dec_seen == 3'd1) begin
						dec_part = (dec_part << 6) | cont;
						dec_seen = 3'd2;
					end else if (dec_seen == 3'd2) begin
						cp = (dec_part << 6) | cont;
						hit = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
				KIND_ED: begin
					if (dec_seen == 3'd1 && b >= 8'h80 && b <= 8'h9f) begin
						dec_kind = KIND_THREE;
						dec_part = (21'h0d << 6) | cont;
						dec_seen = 3'd2;
					end else if (dec_seen == 3'd1 && b >= 8'ha0 && b <= 8'haf) begin
						dec_kind = KIND_PAIR;
						dec_part = {17'd0, b[3:0]};
						dec_seen = 3'd2;
					end else begin
						bad = 1'b1;
					end
				end
				KIND_PAIR: begin
					if (dec_seen == 3'd2 && is_cont(b)) begin
						dec_part = (dec_part << 6) | cont;
						dec_seen = 3'd3;
					end else if (dec_seen == 3'd3 && b == 8'hed) begin
						dec_seen = 3'd4;
					end else if (dec_seen == 3'd4 && b >= 8'hb0 && b <= 8'hbf) begin
						dec_part = ((dec_part << 4) | b[3:0]) & 21'h3fff;
						dec_seen = 3'd5;
					end else if (dec_seen == 3'd5 && is_cont(b)) begin
						cp = 21'h10000 + ((dec_part << 6) | cont);
						hit = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
				default: bad = 1'b1;
			endcase
			if (bad)
				dec_err = 1'b1;
			if (bad || hit) begin
				dec_kind = KIND_NONE;
				dec_seen = '0;
				dec_part = '0;
			end
			if (hit && dec_count != 16'hffff)
				dec_count = dec_count + 16'd1;
		end
		r.point_valid = hit;
		r.code_point = hit ? cp : '0;
		r.string_done = last;
		r.string_ok = last && !dec_err && dec_kind == KIND_NONE;
		r.char_count = dec_count;
		if (last) begin
			dec_kind = KIND_NONE;
			dec_seen = '0;
			dec_part = '0;
			dec_err = 1'b0;
			dec_count = '0;
		end
		return r;
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// output check first, then prediction of the byte taken at this edge
	always @(posedge clk) begin
		dec_result_t want;
		if (!arst_n) begin
			in_fired <= 1'b0;
			out_fired <= 1'b0;
		end else begin
			in_fired <= s_tvalid && s_tready;
			out_fired <= m_tvalid && m_tready;
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected output transfer, expected none actual %0h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("code_point", want.code_point, m_tdata[20:0]);
					check_field("string_ok", want.string_ok, m_tdata[21]);
					check_field("char_count", want.char_count, m_tdata[37:22]);
					check_field("tdata pad", 0, m_tdata[39:38]);
					check_field("string_done", want.string_done, m_tlast);
					check_field("point_valid", want.point_valid, m_tuser);
				end
			end
			if (s_tvalid && s_tready) begin
				results_due.insert(results_due.size(), decode_byte(s_tdata, s_tlast));
				tx_accepted++;
			end
		end
	end

	always @(negedge clk) begin
		byte_xfer_t nxt;
		logic       offer;
		offer = s_tvalid && !in_fired;
		if (!offer) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
			end else if (bytes_to_send.size() > 0) begin
				nxt = bytes_to_send.pop_front();
				s_tdata <= nxt.data;
				s_tlast <= nxt.last;
				offer = 1'b1;
				tx_gap <= tx_no_idle ? 0 : $urandom_range(0, 19);
			end
		end
		s_tvalid <= offer;
	end

	always @(negedge clk) begin
		logic rdy;
		int   w;
		rdy = m_tready;
		if (hold_seen != hold_ticket) begin
			hold_seen <= hold_ticket;
			rx_hold_left <= 300;
			rx_wait <= 0;
			rdy = 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			rdy = 1'b0;
		end else if (out_fired) begin
			w = rx_no_idle ? 0 : $urandom_range(0, 19);
			rx_wait <= w;
			rdy = (w == 0);
		end else if (!m_tready) begin
			if (rx_wait > 1)
				rx_wait <= rx_wait - 1;
			else
				rdy = 1'b1;
		end
		m_tready <= rdy;
	end

	task automatic append_byte(input logic [7:0] v);
		str_bytes.insert(str_bytes.size(), v);
	endtask

	task automatic add_char();
		case ($urandom_range(0, 5))
			0: append_byte(8'($urandom_range(8'h00, 8'h7f)));
			1: begin
				append_byte(8'($urandom_range(8'hc2, 8'hdf)));
				append_byte(8'($urandom_range(8'h80, 8'hbf)));
			end
			2: begin
				append_byte(8'he0);
				append_byte(8'($urandom_range(8'ha0, 8'hbf)));
				append_byte(8'($urandom_range(8'h80, 8'hbf)));
			end
			3: begin
				if ($urandom_range(0, 5) == 0)
					append_byte(8'($urandom_range(8'hee, 8'hef)));
				else
					append_byte(8'($urandom_range(8'he1, 8'hec)));
				append_byte(8'($urandom_range(8'h80, 8'hbf)));
				append_byte(8'($urandom_range(8'h80, 8'hbf)));
			end
			4: begin
				append_byte(8'hed);
				append_byte(8'($urandom_range(8'h80, 8'h9f)));
				append_byte(8'($urandom_range(8'h80, 8'hbf)));
			end
			default: begin
				append_byte(8'hed);
				append_byte(8'($urandom_range(8'ha0, 8'haf)));
				append_byte(8'($urandom_range(8'h80, 8'hbf)));
				append_byte(8'hed);
				append_byte(8'($urandom_range(8'hb0, 8'hbf)));
				append_byte(8'($urandom_range(8'h80, 8'hbf)));
			end
		endcase
	endtask

	// mostly well-formed strings, some corrupted, truncated or pure noise
	task automatic build_string();
		int n;
		int shape;
		str_bytes.delete();
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) append_byte(8'($urandom_range(0, 255)));
		end else begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 4);
			repeat (n) add_char();
			if (shape == 1)
				str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
			else if (shape == 2 && str_bytes.size() > 1)
				void'(str_bytes.pop_back());
			else if (shape == 3)
				append_byte(8'($urandom_range(8'h80, 8'hff)));
		end
	endtask

	task automatic queue_string();
		byte_xfer_t x;
		for (int i = 0; i < str_bytes.size(); i++) begin
			x.data = str_bytes[i];
			x.last = (i == str_bytes.size() - 1);
			bytes_to_send.insert(bytes_to_send.size(), x);
		end
		tx_total += str_bytes.size();
	endtask

	task automatic wait_drained();
		while (tx_accepted != tx_total || results_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int strings;
		strings = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ascii, two-byte, e0, ed and surrogate-pair forms with range edges, then the error cases
		str_bytes = '{8'h00, 8'hc2, 8'h80, 8'hdf, 8'hbf, 8'he0, 8'ha0, 8'h80,
			8'hed, 8'h9f, 8'hbf, 8'hed, 8'ha0, 8'h80, 8'hed, 8'hb0, 8'h80,
			8'hed, 8'haf, 8'hbf, 8'hed, 8'hbf, 8'hbf, 8'h7f};
		queue_string();
		str_bytes = '{8'h80, 8'h41};
		queue_string();
		str_bytes = '{8'he1, 8'h80};
		queue_string();
		str_bytes = '{8'hff};
		queue_string();
		wait_drained();

		// long receiver hold-off with the sender streaming
		tx_no_idle = 1'b1;
		hold_ticket++;
		while (tx_total < 120) begin
			build_string();
			queue_string();
		end
		wait_drained();

		while (tx_total < 900) begin
			if (strings % 12 == 0) begin
				tx_no_idle = ($urandom_range(0, 3) == 0);
				rx_no_idle = ($urandom_range(0, 3) == 0);
			end
			build_string();
			queue_string();
			strings++;
			while (tx_total - tx_accepted > 4)
				@(negedge clk);
			if ($urandom_range(0, 40) == 0)
				wait_drained();
		end
		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/core/cesu8dv_pkg.sv
rtl/core/cesu8dv_front.sv
rtl/core/cesu8dv_back.sv
rtl/core/cesu8_stream_decode_validate.sv
rtl/core/cesu8dv_checker.sv
verif/tb_cesu8_stream_decode_validate.sv
